// ===== rtl/fdrs_pkg.sv =====
// Shared types and constants for the FIFO dispatcher.
package fdrs_pkg;

  localparam int WORD_W = 32;
  localparam int SRV_W = 4;
  localparam int CFG_W = 5;
  localparam int CNT_W = 7;
  localparam int DEFAULT_SERVERS = 10;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_REQ = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

  typedef struct packed {
    logic set;
    logic [SRV_W-1:0] id;
  } arb_req_t;

  typedef struct packed {
    logic any;
    logic [SRV_W-1:0] id;
  } arb_res_t;

endpackage

// ===== rtl/fifo_dispatch_to_requesting_server.sv =====
// Top level: word FIFO as a row of cells, request arbiter and output register.
// Output: a result is registered in the cycle after the input beat that dispatches or drops it.
// Throughput: one word per cycle while in_tready is high; the cell chain shifts and loads in the same cycle.
// Stall: in_tready drops only while a result waits and out_tready is low.
// Reset: clears cell valid bits, the pending bitmap and the output valid bit;
// servers_in_use returns to 10. No clearing pass is needed.
module fifo_dispatch_to_requesting_server #(
  parameter int FIFO_DEPTH = 64,
  parameter int SERVER_LIMIT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], requesting_server[35:32], zero pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // target_server[3:0], sent_word[35:4], zero pad
  output logic        out_tuser   // dropped
);

  logic [fdrs_pkg::CFG_W-1:0]  srv_use_r;
  logic                        in_fire, is_data, drop, push_ok, dispatch;
  logic [fdrs_pkg::WORD_W-1:0] in_word, fifo_head, head_word;
  fdrs_pkg::fifo_ctl_t         fctl;
  fdrs_pkg::fifo_sts_t         sts;
  fdrs_pkg::arb_req_t          areq;
  fdrs_pkg::arb_res_t          ares;

  logic                        out_valid_r, out_valid_nxt;
  logic [fdrs_pkg::SRV_W-1:0]  target_r;
  logic [fdrs_pkg::WORD_W-1:0] sent_r;
  logic                        dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srv_use_r <= fdrs_pkg::CFG_W'(fdrs_pkg::DEFAULT_SERVERS);
    end else if (cfg_wr_en) begin
      srv_use_r <= cfg_wr_data;
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire = in_tvalid && in_tready;
  assign in_word = in_tdata[31:0];
  assign is_data = in_tuser == fdrs_pkg::CMD_DATA;
  assign drop = in_fire && is_data && sts.full;
  assign push_ok = in_fire && is_data && !sts.full;

  assign areq.set = in_fire && (in_tuser == fdrs_pkg::CMD_REQ);
  assign areq.id = in_tdata[35:32];

  // dispatch needs a word after the push and an eligible pending server
  assign dispatch = in_fire && !drop && ares.any && (!sts.empty || push_ok);

  // on an empty FIFO the arriving word goes straight out
  assign fctl.pop = dispatch && !sts.empty;
  assign fctl.push = push_ok && !(dispatch && sts.empty);
  assign head_word = sts.empty ? in_word : fifo_head;

  fdrs_chain #(
    .DEPTH (FIFO_DEPTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fctl),
    .in_word   (in_word),
    .head_word (fifo_head),
    .sts       (sts)
  );

  fdrs_arb #(
    .SERVER_LIMIT (SERVER_LIMIT)
  ) u_arb (
    .clk            (clk),
    .rst_n          (rst_n),
    .servers_in_use (srv_use_r),
    .step           (in_fire),
    .req            (areq),
    .take           (dispatch),
    .res            (ares)
  );

  always_comb begin
    if (in_fire && (drop || dispatch)) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (drop || dispatch)) begin
      target_r <= drop ? '0 : ares.id;
      sent_r <= drop ? '0 : head_word;
      dropped_r <= drop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'b0000, sent_r, target_r};
  assign out_tuser = dropped_r;

  a_sts_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.empty && sts.full))
    else $error("FIFO reports empty and full together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fctl.pop |-> !sts.empty)
    else $error("pop from an empty FIFO");

  a_drop_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop |=> sts.full)
    else $error("FIFO left full state after a drop");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

endmodule

// ===== rtl/fdrs_cell.sv =====
// One FIFO cell: holds a word and its valid bit, shifts toward the head on pop.
module fdrs_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fdrs_pkg::fifo_ctl_t        ctl,
  input  logic [fdrs_pkg::WORD_W-1:0] in_word,
  input  logic [fdrs_pkg::WORD_W-1:0] nb_word,
  input  logic                       nb_valid,
  input  logic                       prev_vs,
  output logic [fdrs_pkg::WORD_W-1:0] word,
  output logic                       valid,
  output logic                       vs
);

  logic [fdrs_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                        valid_r, valid_nxt;
  logic                        load;

  // valid after the shift; the new word lands in the first free cell
  assign vs = ctl.pop ? nb_valid : valid_r;
  assign load = ctl.push && !vs && prev_vs;

  always_comb begin
    if (load) begin
      word_nxt = in_word;
    end else if (ctl.pop) begin
      word_nxt = nb_word;
    end else begin
      word_nxt = word_r;
    end
    valid_nxt = vs || load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  assign valid = valid_r;

endmodule

// ===== rtl/fdrs_chain.sv =====
// Row of FIFO cells with the head at cell 0.
module fdrs_chain #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fdrs_pkg::fifo_ctl_t         ctl,
  input  logic [fdrs_pkg::WORD_W-1:0] in_word,
  output logic [fdrs_pkg::WORD_W-1:0] head_word,
  output fdrs_pkg::fifo_sts_t         sts
);

  logic [fdrs_pkg::WORD_W-1:0] words [DEPTH+1];
  logic [DEPTH:0]              valids;
  logic [DEPTH:0]              vs_chain;

  assign words[DEPTH] = '0;
  assign valids[DEPTH] = 1'b0;
  assign vs_chain[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fdrs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .in_word  (in_word),
      .nb_word  (words[i+1]),
      .nb_valid (valids[i+1]),
      .prev_vs  (vs_chain[i]),
      .word     (words[i]),
      .valid    (valids[i]),
      .vs       (vs_chain[i+1])
    );
  end

  assign head_word = words[0];
  assign sts.empty = !valids[0];
  assign sts.full = valids[DEPTH-1];

endmodule

// ===== rtl/fdrs_arb.sv =====
// Pending request bitmap and fixed-priority pick of the lowest eligible server.
module fdrs_arb #(
  parameter int SERVER_LIMIT = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fdrs_pkg::CFG_W-1:0] servers_in_use,
  input  logic                       step,
  input  fdrs_pkg::arb_req_t         req,
  input  logic                       take,
  output fdrs_pkg::arb_res_t         res
);

  logic [SERVER_LIMIT-1:0]    pend_r, pend_nxt;
  logic [SERVER_LIMIT-1:0]    elig, newv, merged, cand, grant_oh;
  logic [fdrs_pkg::CNT_W-1:0] base, count;

  always_comb begin
    // zero count falls back to the default, then cap at the server limit
    if (servers_in_use == '0) begin
      base = fdrs_pkg::CNT_W'(fdrs_pkg::DEFAULT_SERVERS);
    end else begin
      base = fdrs_pkg::CNT_W'(servers_in_use);
    end
    if (base > fdrs_pkg::CNT_W'(SERVER_LIMIT)) begin
      count = fdrs_pkg::CNT_W'(SERVER_LIMIT);
    end else begin
      count = base;
    end
  end

  always_comb begin
    for (int i = 0; i < SERVER_LIMIT; i++) begin
      elig[i] = fdrs_pkg::CNT_W'(i) < count;
      newv[i] = req.set && elig[i] &&
                (fdrs_pkg::CNT_W'(req.id) == fdrs_pkg::CNT_W'(i));
    end
    merged = pend_r | newv;
    cand = merged & elig;
  end

  always_comb begin
    grant_oh = '0;
    res.any = 1'b0;
    res.id = '0;
    for (int i = SERVER_LIMIT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        grant_oh = '0;
        grant_oh[i] = 1'b1;
        res.any = 1'b1;
        res.id = fdrs_pkg::SRV_W'(i);
      end
    end
  end

  always_comb begin
    if (step) begin
      pend_nxt = take ? (merged & ~grant_oh) : merged;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule
